// ----- src/imabd_pkg.sv -----
// ----------------------------------------------------------------------------
// imabd_pkg
// Types, tables and the per-nibble decode function for the IMA ADPCM byte
// decoder.
// ----------------------------------------------------------------------------
package imabd_pkg;

    localparam int SampleW   = 16;
    localparam int PosW      = 7;
    localparam int StepW     = 15;
    localparam int LastPos   = 88;
    localparam int NumSteps  = LastPos + 1;

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic [PosW-1:0]           t_pos;
    typedef logic [StepW-1:0]          t_step;

    typedef struct packed {
        t_sample pred;
        t_pos    pos;
    } t_dec_state;

    localparam t_step STEP_TABLE [0:NumSteps-1] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] POS_ADJUST [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    localparam t_pos LAST_POS = t_pos'(LastPos);

    function automatic t_dec_state decode_nibble(input t_dec_state st, input logic [3:0] nib);
        t_pos                     idx;
        t_step                    step;
        logic [StepW+1:0]         delta;
        logic signed [SampleW+1:0] sum;
        logic signed [PosW+1:0]   pos;
        t_dec_state               res;
        idx   = (st.pos > LAST_POS) ? LAST_POS : st.pos;
        step  = STEP_TABLE[idx];
        delta = {5'd0, step[StepW-1:3]};
        if (nib[2]) begin
            delta = delta + {2'd0, step};
        end
        if (nib[1]) begin
            delta = delta + {3'd0, step[StepW-1:1]};
        end
        if (nib[0]) begin
            delta = delta + {4'd0, step[StepW-1:2]};
        end
        if (nib[3]) begin
            sum = $signed({{2{st.pred[SampleW-1]}}, st.pred}) - $signed({1'b0, delta});
        end else begin
            sum = $signed({{2{st.pred[SampleW-1]}}, st.pred}) + $signed({1'b0, delta});
        end
        if (sum > 18'sd32767) begin
            res.pred = 16'sh7fff;
        end else if (sum < -18'sd32768) begin
            res.pred = 16'sh8000;
        end else begin
            res.pred = sum[SampleW-1:0];
        end
        pos = $signed({2'b00, idx}) + $signed({{4{POS_ADJUST[nib[2:0]][4]}},
                                                POS_ADJUST[nib[2:0]]});
        if (pos < 0) begin
            res.pos = '0;
        end else if (pos > $signed({2'b00, LAST_POS})) begin
            res.pos = LAST_POS;
        end else begin
            res.pos = pos[PosW-1:0];
        end
        return res;
    endfunction

endpackage

// ----- src/ima_adpcm_byte_decoder_core.sv -----
// ----------------------------------------------------------------------------
// ima_adpcm_byte_decoder_core
// Decodes one byte of 4-bit IMA ADPCM (low nibble, then high nibble) into
// two 16-bit PCM samples per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_ready carries one code byte per item. Output
//   channel o_valid / i_ready carries both decoded samples of that byte.
//   The byte is captured in an input register; both nibbles are decoded by
//   one pass of combinational logic (two chained table reads and adds) and
//   the samples land in the result register together with the new decoder
//   state.
//   Throughput: one item per cycle while the receiver keeps i_ready high,
//   since the decoder state loop through both nibble decodes closes
//   between the input and result registers.
//   Reset clears the predictor and the step index to zero and empties both
//   registers; the state then carries across all items until the next reset.
//   When the receiver stalls, the result register holds, the input register
//   still takes one more item, and o_ready drops once both are full.
// ----------------------------------------------------------------------------
module ima_adpcm_byte_decoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_code_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output imabd_pkg::t_sample o_first_sample,
    output imabd_pkg::t_sample o_second_sample
);
    import imabd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_code;
    logic       r_out_valid;
    t_sample    r_first;
    t_sample    r_second;
    t_dec_state r_state;

    logic       advance;
    t_dec_state n_mid;
    t_dec_state n_state;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // low nibble first, high nibble uses the state it leaves
    always_comb begin
        n_mid   = decode_nibble(r_state, r_code[3:0]);
        n_state = decode_nibble(n_mid, r_code[7:4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code <= i_code_byte;
        end
        if (advance) begin
            r_first  <= n_mid.pred;
            r_second <= n_state.pred;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_first_sample  = r_first;
    assign o_second_sample = r_second;

endmodule
